### hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser and its channels.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_FIRST      = 3'd0,
        PH_LEN        = 3'd1,
        PH_EXT_HI     = 3'd2,
        PH_EXT_LO     = 3'd3,
        PH_MASK_SHORT = 3'd4,
        PH_MASK_LONG  = 3'd5,
        PH_PAYLOAD    = 3'd6,
        PH_DRAIN      = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLOSE   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    localparam logic [3:0]  OPC_TEXT        = 4'h1;
    localparam logic [3:0]  OPC_BINARY      = 4'h2;
    localparam logic [3:0]  OPC_CLOSE       = 4'h8;
    localparam logic [6:0]  LEN_EXT16       = 7'd126;
    localparam logic [6:0]  LEN_EXT64       = 7'd127;
    localparam logic [15:0] MIN_PACKET      = 16'd2;
    localparam logic [15:0] MIN_DATA_PACKET = 16'd6;
    localparam logic [16:0] MASK_END_SHORT  = 17'd5;
    localparam logic [16:0] MASK_END_LONG   = 17'd7;
    localparam logic [16:0] POS_MAX         = 17'h1FFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_length;
        logic        packet_end;
    } t_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_done;
        logic [1:0] frame_status;
    } t_result;

endpackage

### hdl/wsd_if.sv
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface wsd_in_if import wsd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        packet_end;

    modport source (output valid, data_byte, packet_length, packet_end, input ready);
    modport sink   (input valid, data_byte, packet_length, packet_end, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [1:0] frame_status;

    modport source (output valid, payload_valid, payload_byte, frame_done, frame_status,
                    input ready);
    modport sink   (input valid, payload_valid, payload_byte, frame_done, frame_status,
                    output ready);
endinterface

### hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one masked frame per packet and emits unmasked payload bytes with
// a single status result per packet.
// ----------------------------------------------------------------------------
// Each result is held in the input register and then in the result register.
// Throughput: one byte per cycle while the result channel is ready, set by the input and result registers.
// A byte that yields no result still passes through the parser.
// Reset is synchronous and active low; it returns the parser to the start
// of a packet and empties both registers.
module websocket_frame_deframer import wsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out
);

    t_item item;
    logic  item_valid;
    logic  item_take;

    wsd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_take  (item_take)
    );

    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_take  (item_take),
        .o_out        (o_out)
    );

endmodule

### hdl/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer input register
// Captures one received byte per cycle while the parser keeps taking them, and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_reg import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_in_if.sink     i_in,
    output t_item      o_item,
    output logic       o_item_valid,
    input  logic       i_item_take
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign i_in.ready   = !r_valid || i_item_take;
    assign o_item       = r_item;
    assign o_item_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.data_byte     <= i_in.data_byte;
            r_item.packet_length <= i_in.packet_length;
            r_item.packet_end    <= i_in.packet_end;
        end
    end

endmodule

### hdl/wsd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Decodes the frame header, keeps the mask key and unmasks payload bytes.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_item_valid,
    output logic       o_item_take,
    wsd_out_if.source  o_out
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [16:0] r_pos;
    logic [16:0] n_pos;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [7:0]  r_key [4];
    logic        r_out_valid;
    t_result     r_res;

    logic        adv;
    logic        done;
    t_status     status;
    logic        key_we;
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic [15:0] ext_len;
    logic [15:0] dec_count;

    assign adv         = i_item_valid && (!r_out_valid || o_out.ready);
    assign o_item_take = adv;
    assign ext_len     = {r_count[15:8], i_item.data_byte};
    assign dec_count   = r_count - 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_pos   = r_pos;
        done    = 1'b0;
        status  = ST_OK;
        key_we  = 1'b0;
        unique case (r_phase)
            PH_FIRST: begin
                if (i_item.packet_length < MIN_PACKET) begin
                    done   = 1'b1;
                    status = ST_INVALID;
                end else if (!i_item.data_byte[7]) begin
                    done = 1'b1;
                end else if (i_item.data_byte[3:0] == OPC_CLOSE) begin
                    done   = 1'b1;
                    status = ST_CLOSE;
                end else if (i_item.data_byte[3:0] == OPC_TEXT ||
                             i_item.data_byte[3:0] == OPC_BINARY) begin
                    if (i_item.packet_length > MIN_DATA_PACKET) begin
                        n_phase = PH_LEN;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                end
            end
            PH_LEN: begin
                if (i_item.data_byte[6:0] == LEN_EXT64) begin
                    done = 1'b1;
                end else if (i_item.data_byte[6:0] == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else if ({9'd0, i_item.data_byte[6:0]} > i_item.packet_length) begin
                    done   = 1'b1;
                    status = ST_INVALID;
                end else begin
                    n_count = {9'd0, i_item.data_byte[6:0]};
                    n_phase = PH_MASK_SHORT;
                end
            end
            PH_EXT_HI: begin
                n_count = {i_item.data_byte, 8'h00};
                n_phase = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_count = ext_len;
                if (ext_len > i_item.packet_length) begin
                    done   = 1'b1;
                    status = ST_INVALID;
                end else begin
                    n_phase = PH_MASK_LONG;
                end
            end
            PH_MASK_SHORT, PH_MASK_LONG: begin
                key_we = 1'b1;
                if ((r_phase == PH_MASK_SHORT && r_pos == MASK_END_SHORT) ||
                    (r_phase == PH_MASK_LONG && r_pos == MASK_END_LONG)) begin
                    if (r_count == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_count = dec_count;
                if (dec_count == 16'd0) begin
                    done = 1'b1;
                end
            end
            PH_DRAIN: begin
                n_phase = PH_DRAIN;
            end
        endcase

        // A packet that ends before its status was given still closes as ok.
        if (!done && i_item.packet_end && r_phase != PH_DRAIN) begin
            done = 1'b1;
        end
        if (done) begin
            n_phase = PH_DRAIN;
        end

        if (i_item.packet_end) begin
            n_pos   = 17'd0;
            n_phase = PH_FIRST;
            n_count = 16'd0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 17'd1;
        end
    end

    always_comb begin
        pay_valid = (r_phase == PH_PAYLOAD);
        pay_byte  = 8'h00;
        if (pay_valid) begin
            pay_byte = i_item.data_byte ^ r_key[r_pos[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_pos       <= 17'd0;
            r_count     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_count     <= n_count;
                r_out_valid <= pay_valid || done;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && key_we) begin
            r_key[r_pos[1:0]] <= i_item.data_byte;
        end
        if (adv) begin
            r_res.payload_valid <= pay_valid;
            r_res.payload_byte  <= pay_byte;
            r_res.frame_done    <= done;
            r_res.frame_status  <= done ? status : ST_OK;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_valid = r_res.payload_valid;
    assign o_out.payload_byte  = r_res.payload_byte;
    assign o_out.frame_done    = r_res.frame_done;
    assign o_out.frame_status  = r_res.frame_status;

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_item.packet_end |=> r_phase == PH_FIRST && r_pos == 17'd0)
        else $error("packet end did not restart the parser");

    a_payload_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase != PH_PAYLOAD |=> !(r_out_valid && r_res.payload_valid))
        else $error("payload byte emitted outside the payload phase");

    a_mask_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK_SHORT || r_phase == PH_MASK_LONG) |-> r_pos <= MASK_END_LONG)
        else $error("mask key phase past the header");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.frame_done |-> r_res.frame_status == ST_OK)
        else $error("status set on a result that does not finish the frame");

endmodule
